// File: design/seven_point_stencil_matvec_top_assert.svh
`ifndef SEVEN_POINT_STENCIL_MATVEC_TOP_ASSERT_SVH
`define SEVEN_POINT_STENCIL_MATVEC_TOP_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define SPSM_ASSERT_HOLD(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("spsm invariant broken");

// consequence expected in the cycle after the trigger
`define SPSM_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("spsm sequence broken");

`endif

// File: design/spsm_pkg.sv
package spsm_pkg;

  localparam int DEF_MAX_DIM_X = 1024;
  localparam int DEF_MAX_DIM_Y = 64;
  localparam int DEF_MAX_DIM_Z = 64;

  localparam int DATA_W    = 32;
  localparam int DIM_X_W   = 11;
  localparam int DIM_Y_W   = 7;
  localparam int DIM_Z_W   = 7;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_X      = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y      = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Z      = CFG_IDX_W'(6);

  localparam logic OP_SAMPLE = 1'b0;

  // stencil taps; the first six come from the history memories
  localparam int N_TAPS     = 7;
  localparam int N_MEM_TAPS = 6;
  localparam int N_RAMS     = N_MEM_TAPS / 2;
  localparam int TAP_XM     = 0;
  localparam int TAP_YM     = 1;
  localparam int TAP_ZM     = 2;
  localparam int TAP_C      = 3;
  localparam int TAP_ZP     = 4;
  localparam int TAP_YP     = 5;
  localparam int TAP_XP     = 6;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] sample;
  } spsm_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     is_last;
  } spsm_out_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } spsm_cfg_wr_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] center;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } spsm_coef_t;

  // one point leaving the address stage
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic [N_TAPS-1:0]        active;
    logic [N_MEM_TAPS-1:0]    hit;
    logic signed [DATA_W-1:0] sample;
  } spsm_step_t;

endpackage

// File: design/seven_point_stencil_matvec_top.sv
// channel | dir | handshake                 | payload
// in      | in  | in_valid_i / in_stall_o   | in_data_i  (op, sample)
// out     | out | out_valid_o / out_stall_i | out_data_o (result, is_last)
// cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one sample or flush transfer per cycle unless a held result stalls the pipe;
// a result is registered in step, product, sum, accumulator and output stages
// results trail the samples by one plane plus one point, set by the history memories
// the history memories are not cleared after reset, so no start-up pass
// a held result with out_stall_i high freezes the whole pipe and stalls the input
// cfg_ready_o is always high
module seven_point_stencil_matvec_top import spsm_pkg::*; #(
  parameter int MAX_DIM_X = DEF_MAX_DIM_X,
  parameter int MAX_DIM_Y = DEF_MAX_DIM_Y,
  parameter int MAX_DIM_Z = DEF_MAX_DIM_Z
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  spsm_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output spsm_out_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int HIST_DEPTH = 2 * MAX_DIM_Y * MAX_DIM_Z + 1;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  logic                                en;
  logic                                in_fire;
  spsm_cfg_wr_t                        cfg_wr;
  spsm_coef_t                          coef_q, coef_d;
  logic                                mem_we;
  logic [HIST_AW-1:0]                  mem_waddr;
  logic [DATA_W-1:0]                   mem_wdata;
  logic [N_MEM_TAPS-1:0][HIST_AW-1:0]  rd_addr;
  logic [N_MEM_TAPS-1:0][DATA_W-1:0]   tap_rdata;
  spsm_step_t                          step;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign in_fire     = in_valid_i && en;
  assign cfg_ready_o = 1'b1;

  assign cfg_wr.we   = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.idx  = cfg_index_i;
  assign cfg_wr.data = cfg_data_i;

  always_comb begin
    coef_d = coef_q;
    if (cfg_wr.we) begin
      case (cfg_wr.idx)
        CFG_COEF_CENTER: coef_d.center = $signed(cfg_wr.data);
        CFG_COEF_X:      coef_d.x      = $signed(cfg_wr.data);
        CFG_COEF_Y:      coef_d.y      = $signed(cfg_wr.data);
        CFG_COEF_Z:      coef_d.z      = $signed(cfg_wr.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  spsm_ctrl #(
    .MAX_DIM_X (MAX_DIM_X),
    .MAX_DIM_Y (MAX_DIM_Y),
    .MAX_DIM_Z (MAX_DIM_Z)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_fire_i   (in_fire),
    .in_data_i   (in_data_i),
    .cfg_wr_i    (cfg_wr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .rd_addr_o   (rd_addr),
    .step_o      (step)
  );

  // identical copies of the sample history, two read ports each
  for (genvar g = 0; g < N_RAMS; g++) begin : g_hist
    spsm_ram #(
      .DEPTH  (HIST_DEPTH),
      .ADDR_W (HIST_AW)
    ) u_ram (
      .clk_i     (clk_i),
      .en_i      (en),
      .we_i      (mem_we),
      .waddr_i   (mem_waddr),
      .wdata_i   (mem_wdata),
      .raddr_a_i (rd_addr[2*g]),
      .raddr_b_i (rd_addr[2*g+1]),
      .rdata_a_o (tap_rdata[2*g]),
      .rdata_b_o (tap_rdata[2*g+1])
    );
  end

  spsm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .step_i      (step),
    .rdata_i     (tap_rdata),
    .coef_i      (coef_q),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: design/spsm_ram.sv
module spsm_ram import spsm_pkg::*; #(
  parameter int DEPTH  = 2 * DEF_MAX_DIM_Y * DEF_MAX_DIM_Z + 1,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  // read-first: a read at the write address returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (en_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: design/spsm_ctrl.sv
`include "seven_point_stencil_matvec_top_assert.svh"

module spsm_ctrl import spsm_pkg::*; #(
  parameter int MAX_DIM_X = DEF_MAX_DIM_X,
  parameter int MAX_DIM_Y = DEF_MAX_DIM_Y,
  parameter int MAX_DIM_Z = DEF_MAX_DIM_Z,
  localparam int HIST_DEPTH = 2 * MAX_DIM_Y * MAX_DIM_Z + 1,
  localparam int HIST_AW    = $clog2(HIST_DEPTH)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 in_fire_i,
  input  spsm_in_t                             in_data_i,
  input  spsm_cfg_wr_t                         cfg_wr_i,
  output logic                                 mem_we_o,
  output logic [HIST_AW-1:0]                   mem_waddr_o,
  output logic [DATA_W-1:0]                    mem_wdata_o,
  output logic [N_MEM_TAPS-1:0][HIST_AW-1:0]   rd_addr_o,
  output spsm_step_t                           step_o
);

  localparam int PLANE_MAX = MAX_DIM_Y * MAX_DIM_Z;
  localparam int XW        = $clog2(MAX_DIM_X + 1);
  localparam int YW        = $clog2(MAX_DIM_Y + 1);
  localparam int ZW        = $clog2(MAX_DIM_Z + 1);
  localparam int PW        = $clog2(PLANE_MAX + 1);
  localparam int PMW       = YW + ZW;
  localparam int LW        = $clog2(PLANE_MAX + 2);
  localparam int AW1       = HIST_AW + 1;

  function automatic logic [31:0] eff_dim(input logic [31:0] v, input logic [31:0] lim);
    logic [31:0] r;
    if (v == '0) begin
      r = 32'd1;
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [HIST_AW-1:0] ring_up(input logic [HIST_AW-1:0] base,
                                                 input logic [HIST_AW-1:0] k);
    logic [HIST_AW:0] s;
    s = {1'b0, base} + {1'b0, k};
    if (s >= AW1'(HIST_DEPTH)) begin
      s = s - AW1'(HIST_DEPTH);
    end
    return s[HIST_AW-1:0];
  endfunction

  function automatic logic [HIST_AW-1:0] ring_dn(input logic [HIST_AW-1:0] base,
                                                 input logic [HIST_AW-1:0] k);
    logic [HIST_AW-1:0] r;
    if (base >= k) begin
      r = base - k;
    end else begin
      r = base + HIST_AW'(HIST_DEPTH) - k;
    end
    return r;
  endfunction

  logic [XW-1:0]      nx_q, nx_d;
  logic [YW-1:0]      ny_q, ny_d;
  logic [ZW-1:0]      nz_q, nz_d;
  logic [PW-1:0]      plane_q, plane_d;
  logic [PMW-1:0]     plane_prod;
  logic [XW-1:0]      ax_q, ax_d;
  logic [YW-1:0]      ay_q, ay_d;
  logic [ZW-1:0]      az_q, az_d;
  logic               all_in_q, all_in_d;
  logic [XW-1:0]      ox_q, ox_d;
  logic [YW-1:0]      oy_q, oy_d;
  logic [ZW-1:0]      oz_q, oz_d;
  logic [LW-1:0]      lead_q, lead_d;
  logic [HIST_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [HIST_AW-1:0] ctr_ptr_q, ctr_ptr_d;
  spsm_step_t         step_q, step_d;

  logic          dim_wr;
  logic          arrive;
  logic          a_end;
  logic          ox_end, oy_end, oz_end;
  logic          last;
  logic          emit;
  logic          all_in_a;
  logic [LW-1:0] lead_a;
  logic [HIST_AW-1:0] ptr_gap;

  assign dim_wr = cfg_wr_i.we && (cfg_wr_i.idx == CFG_DIM_X || cfg_wr_i.idx == CFG_DIM_Y ||
                                  cfg_wr_i.idx == CFG_DIM_Z);

  assign arrive = in_fire_i && (in_data_i.op == OP_SAMPLE) && !all_in_q;
  assign a_end  = (ax_q == nx_q - XW'(1)) && (ay_q == ny_q - YW'(1)) &&
                  (az_q == nz_q - ZW'(1));
  assign ox_end = (ox_q == nx_q - XW'(1));
  assign oy_end = (oy_q == ny_q - YW'(1));
  assign oz_end = (oz_q == nz_q - ZW'(1));
  assign last   = ox_end && oy_end && oz_end;

  assign lead_a   = lead_q + LW'(arrive);
  assign all_in_a = all_in_q || (arrive && a_end);
  // a point is released once its x+1 neighbour is in, or the whole grid is
  assign emit     = in_fire_i && (all_in_a || lead_a == LW'(plane_q) + LW'(1));

  assign plane_prod = PMW'(ny_d) * PMW'(nz_d);
  assign plane_d    = PW'(plane_prod);

  always_comb begin
    nx_d      = nx_q;
    ny_d      = ny_q;
    nz_d      = nz_q;
    ax_d      = ax_q;
    ay_d      = ay_q;
    az_d      = az_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    oz_d      = oz_q;
    wr_ptr_d  = wr_ptr_q;
    ctr_ptr_d = ctr_ptr_q;
    all_in_d  = all_in_a;
    lead_d    = emit ? lead_a - LW'(1) : lead_a;

    if (arrive) begin
      wr_ptr_d = (wr_ptr_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wr_ptr_q + HIST_AW'(1);
      if (az_q == nz_q - ZW'(1)) begin
        az_d = '0;
        if (ay_q == ny_q - YW'(1)) begin
          ay_d = '0;
          ax_d = ax_q + XW'(1);
        end else begin
          ay_d = ay_q + YW'(1);
        end
      end else begin
        az_d = az_q + ZW'(1);
      end
    end

    if (emit) begin
      ctr_ptr_d = (ctr_ptr_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : ctr_ptr_q + HIST_AW'(1);
      if (oz_end) begin
        oz_d = '0;
        if (oy_end) begin
          oy_d = '0;
          ox_d = ox_q + XW'(1);
        end else begin
          oy_d = oy_q + YW'(1);
        end
      end else begin
        oz_d = oz_q + ZW'(1);
      end
    end

    // end of grid or a new geometry starts the stream afresh
    if ((emit && last) || dim_wr) begin
      ax_d      = '0;
      ay_d      = '0;
      az_d      = '0;
      ox_d      = '0;
      oy_d      = '0;
      oz_d      = '0;
      all_in_d  = 1'b0;
      lead_d    = '0;
      wr_ptr_d  = '0;
      ctr_ptr_d = '0;
    end

    if (cfg_wr_i.we) begin
      case (cfg_wr_i.idx)
        CFG_DIM_X: nx_d = XW'(eff_dim(32'(cfg_wr_i.data[DIM_X_W-1:0]), 32'(MAX_DIM_X)));
        CFG_DIM_Y: ny_d = YW'(eff_dim(32'(cfg_wr_i.data[DIM_Y_W-1:0]), 32'(MAX_DIM_Y)));
        CFG_DIM_Z: nz_d = ZW'(eff_dim(32'(cfg_wr_i.data[DIM_Z_W-1:0]), 32'(MAX_DIM_Z)));
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_addr_o[TAP_XM] = ring_dn(ctr_ptr_q, HIST_AW'(plane_q));
    rd_addr_o[TAP_YM] = ring_dn(ctr_ptr_q, HIST_AW'(nz_q));
    rd_addr_o[TAP_ZM] = ring_dn(ctr_ptr_q, HIST_AW'(1));
    rd_addr_o[TAP_C]  = ctr_ptr_q;
    rd_addr_o[TAP_ZP] = ring_up(ctr_ptr_q, HIST_AW'(1));
    rd_addr_o[TAP_YP] = ring_up(ctr_ptr_q, HIST_AW'(nz_q));
  end

  always_comb begin
    step_d.valid          = emit;
    step_d.last           = last;
    step_d.active[TAP_XM] = (ox_q != '0);
    step_d.active[TAP_YM] = (oy_q != '0);
    step_d.active[TAP_ZM] = (oz_q != '0);
    step_d.active[TAP_C]  = 1'b1;
    step_d.active[TAP_ZP] = !oz_end;
    step_d.active[TAP_YP] = !oy_end;
    step_d.active[TAP_XP] = !ox_end;
    // a neighbour arriving in this very transfer bypasses the memory
    for (int i = 0; i < N_MEM_TAPS; i++) begin
      step_d.hit[i] = arrive && (rd_addr_o[i] == wr_ptr_q);
    end
    step_d.sample = in_data_i.sample;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q      <= XW'(1);
      ny_q      <= YW'(1);
      nz_q      <= ZW'(1);
      plane_q   <= PW'(1);
      ax_q      <= '0;
      ay_q      <= '0;
      az_q      <= '0;
      all_in_q  <= 1'b0;
      ox_q      <= '0;
      oy_q      <= '0;
      oz_q      <= '0;
      lead_q    <= '0;
      wr_ptr_q  <= '0;
      ctr_ptr_q <= '0;
      step_q    <= '0;
    end else begin
      nx_q      <= nx_d;
      ny_q      <= ny_d;
      nz_q      <= nz_d;
      plane_q   <= plane_d;
      ax_q      <= ax_d;
      ay_q      <= ay_d;
      az_q      <= az_d;
      all_in_q  <= all_in_d;
      ox_q      <= ox_d;
      oy_q      <= oy_d;
      oz_q      <= oz_d;
      lead_q    <= lead_d;
      wr_ptr_q  <= wr_ptr_d;
      ctr_ptr_q <= ctr_ptr_d;
      if (en_i) begin
        step_q <= step_d;
      end
    end
  end

  assign mem_we_o    = arrive;
  assign mem_waddr_o = wr_ptr_q;
  assign mem_wdata_o = in_data_i.sample;
  assign step_o      = step_q;

  assign ptr_gap = (wr_ptr_q >= ctr_ptr_q) ? wr_ptr_q - ctr_ptr_q
                                           : wr_ptr_q + HIST_AW'(HIST_DEPTH) - ctr_ptr_q;

  `SPSM_ASSERT_HOLD(a_lead_bounded, lead_q <= LW'(plane_q) + LW'(1))
  `SPSM_ASSERT_HOLD(a_ptr_gap_is_lead, ptr_gap == HIST_AW'(lead_q))
  `SPSM_ASSERT_NEXT(a_last_clears, emit && last,
                    lead_q == '0 && !all_in_q && wr_ptr_q == '0 && ctr_ptr_q == '0)

endmodule

// File: design/spsm_mac.sv
module spsm_mac import spsm_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  spsm_step_t                        step_i,
  input  logic [N_MEM_TAPS-1:0][DATA_W-1:0] rdata_i,
  input  spsm_coef_t                        coef_i,
  output logic                              out_valid_o,
  output spsm_out_t                         out_data_o
);

  localparam logic signed [64:0] ROUND_HALF = 65'sd32768;

  logic signed [DATA_W-1:0] tap_v  [N_TAPS];
  logic signed [DATA_W-1:0] coef_v [N_TAPS];

  logic signed [63:0] prod_q [N_TAPS];
  logic signed [64:0] sum4_q [4];
  logic signed [65:0] sum2_q [2];
  logic signed [66:0] acc_q;
  logic signed [64:0] sum4_d [4];
  logic signed [65:0] sum2_d [2];
  logic signed [66:0] acc_d;

  logic v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic l2_q, l3_q, l4_q, l5_q;
  spsm_out_t out_q;
  spsm_out_t out_d;
  logic      fits;

  always_comb begin
    for (int i = 0; i < N_MEM_TAPS; i++) begin
      if (!step_i.active[i]) begin
        tap_v[i] = '0;
      end else if (step_i.hit[i]) begin
        tap_v[i] = step_i.sample;
      end else begin
        tap_v[i] = $signed(rdata_i[i]);
      end
    end
    tap_v[TAP_XP] = step_i.active[TAP_XP] ? step_i.sample : '0;

    coef_v[TAP_XM] = coef_i.x;
    coef_v[TAP_XP] = coef_i.x;
    coef_v[TAP_YM] = coef_i.y;
    coef_v[TAP_YP] = coef_i.y;
    coef_v[TAP_ZM] = coef_i.z;
    coef_v[TAP_ZP] = coef_i.z;
    coef_v[TAP_C]  = coef_i.center;
  end

  // exact sum over a small registered tree, rounding offset rides along
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum4_d[j] = 65'(prod_q[2*j]) + 65'(prod_q[2*j+1]);
    end
    sum4_d[3] = 65'(prod_q[TAP_XP]) + ROUND_HALF;
    for (int k = 0; k < 2; k++) begin
      sum2_d[k] = 66'(sum4_q[2*k]) + 66'(sum4_q[2*k+1]);
    end
    acc_d = 67'(sum2_q[0]) + 67'(sum2_q[1]);
  end

  // shift by 16 then clamp to the Q16.16 range
  assign fits = (&acc_q[66:47]) || !(|acc_q[66:47]);

  always_comb begin
    out_d.is_last = l5_q;
    if (fits) begin
      out_d.result = $signed(acc_q[47:16]);
    end else if (acc_q[66]) begin
      out_d.result = 32'sh8000_0000;
    end else begin
      out_d.result = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      v2_q        <= step_i.valid;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N_TAPS; i++) begin
        prod_q[i] <= 64'(tap_v[i]) * 64'(coef_v[i]);
      end
      l2_q   <= step_i.last;
      sum4_q <= sum4_d;
      l3_q   <= l2_q;
      sum2_q <= sum2_d;
      l4_q   <= l3_q;
      acc_q  <= acc_d;
      l5_q   <= l4_q;
      out_q  <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/sv/seven_point_stencil_matvec_top_test.sv
module seven_point_stencil_matvec_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spsm_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 3;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1950;
  localparam int CALM_ITEMS     = 150;
  localparam int MAX_REPORTS    = 20;
  localparam int HIST_DEPTH     = 2 * DEF_MAX_DIM_Y * DEF_MAX_DIM_Z + 1;
  localparam int unsigned NO_PAUSE = 32'hFFFF_FFFF;

  localparam logic                 OP_FLUSH  = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(7);

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  spsm_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  spsm_out_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i  = '0;

  seven_point_stencil_matvec_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // stencil state as the block should hold it
  logic [DATA_W-1:0]        grid_hist [HIST_DEPTH];
  int unsigned              taken, pos_x, pos_y, pos_z;
  logic [DIM_X_W-1:0]       dim_x_reg = DIM_X_W'(1);
  logic [DIM_Y_W-1:0]       dim_y_reg = DIM_Y_W'(1);
  logic [DIM_Z_W-1:0]       dim_z_reg = DIM_Z_W'(1);
  logic signed [DATA_W-1:0] wt_center = '0;
  logic signed [DATA_W-1:0] wt_x      = '0;
  logic signed [DATA_W-1:0] wt_y      = '0;
  logic signed [DATA_W-1:0] wt_z      = '0;

  spsm_out_t   pending_results [$];
  spsm_out_t   head;
  bit          calm = 1'b0;
  int unsigned errors, checked, grids_done, items_used;
  int unsigned samples_sent, flushes_sent, settings, quiet_cycles;

  function automatic int unsigned span(input int unsigned raw, input int unsigned max_v);
    if (raw == 0) return 1;
    if (raw > max_v) return max_v;
    return raw;
  endfunction

  function automatic int unsigned grid_points();
    return span(32'(dim_x_reg), DEF_MAX_DIM_X) * span(32'(dim_y_reg), DEF_MAX_DIM_Y)
         * span(32'(dim_z_reg), DEF_MAX_DIM_Z);
  endfunction

  function automatic void clear_grid();
    taken = 0;
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
  endfunction

  function automatic logic signed [71:0] tap(input logic signed [DATA_W-1:0] k,
                                             input int unsigned q);
    logic signed [71:0] a, b;
    a = 72'(k);
    b = 72'($signed(grid_hist[q % HIST_DEPTH]));
    return a * b;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DATA_W-1:0] val);
    case (idx)
      CFG_DIM_X: begin
        dim_x_reg = val[DIM_X_W-1:0];
        clear_grid();
      end
      CFG_DIM_Y: begin
        dim_y_reg = val[DIM_Y_W-1:0];
        clear_grid();
      end
      CFG_DIM_Z: begin
        dim_z_reg = val[DIM_Z_W-1:0];
        clear_grid();
      end
      CFG_COEF_CENTER: wt_center = val;
      CFG_COEF_X:      wt_x = val;
      CFG_COEF_Y:      wt_y = val;
      CFG_COEF_Z:      wt_z = val;
      default: ;
    endcase
  endfunction

  // advance the expected state by one input transfer
  function automatic void stencil_step(input spsm_in_t item);
    int unsigned nx, ny, nz, plane, total, o, need;
    logic signed [71:0] acc;
    spsm_out_t r;
    nx = span(32'(dim_x_reg), DEF_MAX_DIM_X);
    ny = span(32'(dim_y_reg), DEF_MAX_DIM_Y);
    nz = span(32'(dim_z_reg), DEF_MAX_DIM_Z);
    plane = ny * nz;
    total = nx * plane;
    if (item.op == OP_SAMPLE && taken < total) begin
      grid_hist[taken % HIST_DEPTH] = item.sample;
      taken++;
    end
    o = (pos_x * ny + pos_y) * nz + pos_z;
    need = o + plane + 1;
    if (need > total) need = total;
    if (taken < need) return;

    acc = tap(wt_center, o);
    if (pos_x > 0)       acc += tap(wt_x, o - plane);
    if (pos_x + 1 < nx)  acc += tap(wt_x, o + plane);
    if (pos_y > 0)       acc += tap(wt_y, o - nz);
    if (pos_y + 1 < ny)  acc += tap(wt_y, o + nz);
    if (pos_z > 0)       acc += tap(wt_z, o - 1);
    if (pos_z + 1 < nz)  acc += tap(wt_z, o + 1);
    // round half up, then back to q16.16 with saturation
    acc = (acc + 72'sd32768) >>> 16;
    if (acc > 72'sd2147483647) r.result = 32'sh7FFF_FFFF;
    else if (acc < -72'sd2147483648) r.result = 32'sh8000_0000;
    else r.result = acc[DATA_W-1:0];
    r.is_last = (o + 1 == total);
    pending_results.push_back(r);

    if (r.is_last) begin
      clear_grid();
      grids_done++;
    end else if (++pos_z >= nz) begin
      pos_z = 0;
      if (++pos_y >= ny) begin
        pos_y = 0;
        pos_x++;
      end
    end
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    logic signed [19:0] modest;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom();
      default: begin
        modest = 20'($urandom());
        return 32'(modest);
      end
    endcase
  endfunction

  // output side: random stall bursts
  always begin
    @(posedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got %h last %b",
                   $time, out_data_o.result, out_data_o.is_last);
      end else begin
        head = pending_results.pop_front();
        checked++;
        if (out_data_o.result !== head.result) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result mismatch, expected %h got %h",
                     $time, head.result, out_data_o.result);
        end
        if (out_data_o.is_last !== head.is_last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: is_last mismatch, expected %b got %b",
                     $time, head.is_last, out_data_o.is_last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("seven_point_stencil_matvec_top_test: errors");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [DATA_W-1:0] val);
    spsm_in_t item;
    item.op = op;
    item.sample = val;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    stencil_step(item);
    items_used++;
    if (op == OP_SAMPLE) samples_sent++;
    else flushes_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // the block may still be busy on transfers that release nothing
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
  endtask

  task automatic set_shape(input logic [DIM_X_W-1:0] nx, input logic [DIM_Y_W-1:0] ny,
                           input logic [DIM_Z_W-1:0] nz);
    logic [DATA_W-1:0] wx, wy, wz;
    // junk above the field must be ignored
    wx = $urandom();
    wy = $urandom();
    wz = $urandom();
    wx[DIM_X_W-1:0] = nx;
    wy[DIM_Y_W-1:0] = ny;
    wz[DIM_Z_W-1:0] = nz;
    settle();
    write_reg(CFG_DIM_X, wx);
    write_reg(CFG_DIM_Y, wy);
    write_reg(CFG_DIM_Z, wz);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  task automatic set_weights(input logic [DATA_W-1:0] kc, input logic [DATA_W-1:0] kx,
                             input logic [DATA_W-1:0] ky, input logic [DATA_W-1:0] kz);
    settle();
    write_reg(CFG_COEF_CENTER, kc);
    write_reg(CFG_COEF_X, kx);
    write_reg(CFG_COEF_Y, ky);
    write_reg(CFG_COEF_Z, kz);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  task automatic stream_grid(input int unsigned n, input int unsigned pause_at);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == pause_at) drain_results();
      if ($urandom_range(0, 99) < 12) send_item(OP_FLUSH, $urandom());
      send_item(OP_SAMPLE, pick_value());
    end
  endtask

  // finish whatever grid is open, with the odd surplus sample once it is full
  task automatic drain_grid();
    while (taken != 0) begin
      if (taken < grid_points() || $urandom_range(0, 9) == 0)
        send_item(OP_SAMPLE, pick_value());
      else
        send_item(OP_FLUSH, $urandom());
    end
  endtask

  task automatic test_reset_state();
    send_item(OP_SAMPLE, $urandom());
    send_item(OP_FLUSH, $urandom());
  endtask

  task automatic test_spare_register();
    settle();
    write_reg(CFG_SPARE, $urandom());
    cfg_valid_i <= 1'b0;
    send_item(OP_SAMPLE, $urandom());
  endtask

  task automatic test_rounding();
    set_shape(DIM_X_W'(1), DIM_Y_W'(1), DIM_Z_W'(1));
    set_weights(32'h0000_8000, 32'h0, 32'h0, 32'h0);
    send_item(OP_SAMPLE, 32'h0000_0001);
    send_item(OP_SAMPLE, 32'hFFFF_FFFF);
    send_item(OP_SAMPLE, 32'h0000_0003);
    send_item(OP_SAMPLE, 32'hFFFF_FFFD);
  endtask

  task automatic test_saturation();
    set_weights(32'h8000_0000, $urandom(), $urandom(), $urandom());
    send_item(OP_SAMPLE, 32'h7FFF_FFFF);
    send_item(OP_SAMPLE, 32'h8000_0000);
    send_item(OP_SAMPLE, 32'h0000_0001);
  endtask

  // three-neighbour stencil at every corner of a 2x2x2 cube, surplus sample, idle flush
  task automatic test_small_cube();
    logic [DATA_W-1:0] vals [8];
    vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
             32'h0000_0001, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    set_shape(DIM_X_W'(2), DIM_Y_W'(2), DIM_Z_W'(2));
    set_weights(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 32'hFFFF_8000);
    foreach (vals[i]) send_item(OP_SAMPLE, vals[i]);
    send_item(OP_SAMPLE, 32'h1234_5678);
    drain_grid();
    send_item(OP_FLUSH, $urandom());
  endtask

  task automatic test_dimension_limits();
    // y above its maximum, z as zero; sender waits for results part way
    set_shape(DIM_X_W'(1), DIM_Y_W'(127), DIM_Z_W'(0));
    set_weights(pick_value(), pick_value(), pick_value(), pick_value());
    stream_grid(grid_points(), 30);
    drain_grid();
    set_shape(DIM_X_W'(2), DIM_Y_W'(0), DIM_Z_W'(127));
    set_weights(pick_value(), pick_value(), pick_value(), pick_value());
    stream_grid(grid_points(), NO_PAUSE);
    drain_grid();
    // largest grid: only a partial one, cut short by the next shape write
    set_shape(DIM_X_W'(2047), DIM_Y_W'(127), DIM_Z_W'(127));
    stream_grid(40, NO_PAUSE);
  endtask

  task automatic test_long_axis();
    set_shape(DIM_X_W'(DEF_MAX_DIM_X), DIM_Y_W'(1), DIM_Z_W'(1));
    set_weights(pick_value(), pick_value(), pick_value(), pick_value());
    stream_grid(grid_points(), NO_PAUSE);
    drain_grid();
  endtask

  task automatic test_random_grids();
    int unsigned shape, total, n, pause_at;
    while (items_used < ITEM_TARGET) begin
      if (items_used + CALM_ITEMS >= ITEM_TARGET) calm = 1'b1;
      shape = $urandom_range(0, 19);
      if (shape < 15)
        set_shape(DIM_X_W'($urandom_range(1, 5)), DIM_Y_W'($urandom_range(1, 5)),
                  DIM_Z_W'($urandom_range(1, 5)));
      else if (shape < 17)
        set_shape(DIM_X_W'($urandom_range(1, 2)), DIM_Y_W'($urandom_range(1, 10)),
                  DIM_Z_W'($urandom_range(1, 10)));
      else if (shape < 19)
        set_shape(DIM_X_W'($urandom()), DIM_Y_W'($urandom()), DIM_Z_W'($urandom()));
      // shape 19 keeps the grid open and only changes the weights
      set_weights(pick_value(), pick_value(), pick_value(), pick_value());
      total = grid_points();
      pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, total - 1) : NO_PAUSE;
      if ((shape < 17 || total <= 60) && $urandom_range(0, 9) != 0) begin
        stream_grid(total, pause_at);
        drain_grid();
      end else if ($urandom_range(0, 1) == 0) begin
        n = $urandom_range(1, (total < 60) ? total : 60);
        stream_grid(n, NO_PAUSE);
        repeat ($urandom_range(0, 5)) send_item(OP_FLUSH, $urandom());
      end else begin
        repeat ($urandom_range(20, 40))
          send_item($urandom_range(0, 1) ? OP_FLUSH : OP_SAMPLE, pick_value());
      end
    end
  endtask

  initial begin
    clear_grid();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_spare_register();
    test_rounding();
    test_saturation();
    test_small_cube();
    test_dimension_limits();
    test_long_axis();
    test_random_grids();
    settle();
    $display("run: %0d samples, %0d flush ticks, %0d register settings incl. dim extremes",
             samples_sent, flushes_sent, settings);
    $display("run: %0d results compared, %0d full grids, %0d mismatches",
             checked, grids_done, errors);
    if (errors == 0) begin
      $display("seven_point_stencil_matvec_top_test: clean");
    end else begin
      $display("seven_point_stencil_matvec_top_test: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/spsm_pkg.sv
design/spsm_ram.sv
design/spsm_ctrl.sv
design/spsm_mac.sv
design/seven_point_stencil_matvec_top.sv
tb/sv/seven_point_stencil_matvec_top_test.sv
